// File: rtl/dsfp_pkg.sv
`timescale 1ns / 1ps

package dsfp_pkg;

   localparam int unsigned MinFrameBytes = 6;
   localparam int unsigned PosWidth      = 3;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 8;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_TYPE     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_LOST       = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_DELIVERED  = 2'd2;

   // result tags
   localparam logic [3:0] TAG_FINAL_FRAME     = 4'd0;
   localparam logic [3:0] TAG_BUFFER_SIZE     = 4'd1;
   localparam logic [3:0] TAG_DATA_RATE       = 4'd2;
   localparam logic [3:0] TAG_LOST_COUNT      = 4'd3;
   localparam logic [3:0] TAG_LOST_START      = 4'd4;
   localparam logic [3:0] TAG_LOST_END        = 4'd5;
   localparam logic [3:0] TAG_HIGHEST_DLV     = 4'd6;
   localparam logic [3:0] TAG_HIGHEST_TX      = 4'd7;
   localparam logic [3:0] TAG_CAUSE           = 4'd8;
   localparam logic [3:0] TAG_DLV_RETX        = 4'd9;
   localparam logic [3:0] TAG_RETX            = 4'd10;
   localparam logic [3:0] TAG_DLV_COUNT       = 4'd11;
   localparam logic [3:0] TAG_DLV_START       = 4'd12;
   localparam logic [3:0] TAG_DLV_END         = 4'd13;
   localparam logic [3:0] TAG_END_STATUS      = 4'd14;

   // end status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
   localparam logic [2:0] ST_WRONG_TYPE  = 3'd2;
   localparam logic [2:0] ST_TRUNCATED   = 3'd3;
   localparam logic [2:0] ST_TOO_MANY    = 3'd4;

   typedef enum logic [3:0] {
      SEC_HDR0  = 4'd0,
      SEC_HDR1  = 4'd1,
      SEC_BUF   = 4'd2,
      SEC_RATE  = 4'd3,
      SEC_LCNT  = 4'd4,
      SEC_LPAIR = 4'd5,
      SEC_HDSN  = 4'd6,
      SEC_HTSN  = 4'd7,
      SEC_CAUSE = 4'd8,
      SEC_DRSN  = 4'd9,
      SEC_RSN   = 4'd10,
      SEC_DCNT  = 4'd11,
      SEC_DPAIR = 4'd12,
      SEC_DONE  = 4'd13,
      SEC_STOP  = 4'd14
   } sec_type;

   typedef struct packed {
      logic [3:0]  expected_frame_type;
      logic [7:0]  max_lost_ranges;
      logic [7:0]  max_delivered_ranges;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  tag;
      logic [31:0] value;
      logic [7:0]  range_index;
      logic [2:0]  status;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic sec_present(input sec_type s, input logic [8:0] flags);
      logic p;
      p = 1'b0;
      case (s)
         SEC_BUF:   p = 1'b1;
         SEC_RATE:  p = flags[7];
         SEC_LCNT:  p = flags[0];
         SEC_HDSN:  p = flags[2];
         SEC_HTSN:  p = flags[3];
         SEC_CAUSE: p = flags[4];
         SEC_DRSN:  p = flags[5];
         SEC_RSN:   p = flags[6];
         SEC_DCNT:  p = flags[8];
         default:   p = 1'b0;
      endcase
      return p;
   endfunction

   // first present section after s, else done
   function automatic sec_type next_section(input sec_type s, input logic [8:0] flags);
      sec_type r;
      r = SEC_DONE;
      for (int i = int'(SEC_DPAIR); i >= int'(SEC_BUF); i--) begin
         if (4'(i) > s && sec_present(sec_type'(4'(i)), flags)) begin
            r = sec_type'(4'(i));
         end
      end
      return r;
   endfunction

   function automatic logic [2:0] field_len(input sec_type s);
      logic [2:0] n;
      case (s)
         SEC_BUF, SEC_RATE: n = 3'd4;
         SEC_CAUSE:         n = 3'd1;
         default:           n = 3'd3;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] field_tag(input sec_type s);
      logic [3:0] t;
      case (s)
         SEC_BUF:   t = TAG_BUFFER_SIZE;
         SEC_RATE:  t = TAG_DATA_RATE;
         SEC_HDSN:  t = TAG_HIGHEST_DLV;
         SEC_HTSN:  t = TAG_HIGHEST_TX;
         SEC_CAUSE: t = TAG_CAUSE;
         SEC_DRSN:  t = TAG_DLV_RETX;
         default:   t = TAG_RETX;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/dsfp_if.sv
`timescale 1ns / 1ps

interface dsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dsfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  tag;
   logic [31:0] value;
   logic [7:0]  range_index;
   logic [2:0]  status;
   logic        frame_end;

   modport source (output valid, output tag, output value, output range_index,
                   output status, output frame_end, input ready);
   modport sink   (input valid, input tag, input value, input range_index,
                   input status, input frame_end, output ready);
endinterface

// File: rtl/dsfp_parser.sv
`timescale 1ns / 1ps

module dsfp_parser
   import dsfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  cfg_type    cfg,
   output push_type   push
);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [8:0]          flags_ff, flags_in;
   sec_type             sec_ff, sec_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [31:0]         acc_ff, acc_in;
   logic [7:0]          left_ff, left_in;
   logic [7:0]          rc_ff, rc_in;
   logic                eop_ff, eop_in;
   logic [2:0]          err_ff, err_in;

   logic [31:0] acc_shift;
   logic [2:0]  cnt_inc;
   logic [7:0]  left_dec;
   logic [7:0]  limit;
   logic        is_lost;
   logic        field_v;
   rsp_type     field_r;
   rsp_type     end_r;
   logic [2:0]  st;

   always_comb begin
      pos_in   = pos_ff;
      flags_in = flags_ff;
      sec_in   = sec_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      rc_in    = rc_ff;
      eop_in   = eop_ff;
      err_in   = err_ff;
      field_v  = 1'b0;
      field_r  = '0;
      end_r    = '0;
      st       = ST_OK;
      push     = '0;

      acc_shift = {acc_ff[23:0], data_byte};
      cnt_inc   = cnt_ff + 3'd1;
      left_dec  = left_ff - 8'd1;
      is_lost   = (sec_ff == SEC_LCNT) || (sec_ff == SEC_LPAIR);
      limit     = is_lost ? cfg.max_lost_ranges : cfg.max_delivered_ranges;

      unique case (sec_ff)
         SEC_HDR0: begin
            flags_in = {5'd0, data_byte[3:0]};
            if (data_byte[7:4] != cfg.expected_frame_type) begin
               err_in = ST_WRONG_TYPE;
               sec_in = SEC_STOP;
            end else begin
               sec_in = SEC_HDR1;
            end
         end
         SEC_HDR1: begin
            flags_in        = {data_byte[4:0], flags_ff[3:0]};
            field_v         = 1'b1;
            field_r.tag     = TAG_FINAL_FRAME;
            field_r.value   = {31'd0, flags_ff[1]};
            sec_in          = next_section(SEC_HDR1, flags_in);
            cnt_in          = '0;
            acc_in          = '0;
         end
         SEC_BUF, SEC_RATE, SEC_HDSN, SEC_HTSN, SEC_CAUSE, SEC_DRSN, SEC_RSN: begin
            if (cnt_inc >= field_len(sec_ff)) begin
               field_v       = 1'b1;
               field_r.tag   = field_tag(sec_ff);
               field_r.value = acc_shift;
               sec_in        = next_section(sec_ff, flags_ff);
               cnt_in        = '0;
               acc_in        = '0;
            end else begin
               cnt_in = cnt_inc;
               acc_in = acc_shift;
            end
         end
         SEC_LCNT, SEC_DCNT: begin
            if (data_byte > limit) begin
               err_in = ST_TOO_MANY;
               sec_in = SEC_STOP;
            end else begin
               field_v       = 1'b1;
               field_r.tag   = is_lost ? TAG_LOST_COUNT : TAG_DLV_COUNT;
               field_r.value = {24'd0, data_byte};
               left_in       = data_byte;
               rc_in         = '0;
               eop_in        = 1'b0;
               cnt_in        = '0;
               acc_in        = '0;
               // an empty list skips its pair section
               if (data_byte == 8'd0) begin
                  sec_in = next_section(sec_type'(sec_ff + 4'd1), flags_ff);
               end else begin
                  sec_in = sec_type'(sec_ff + 4'd1);
               end
            end
         end
         SEC_LPAIR, SEC_DPAIR: begin
            if (cnt_inc >= 3'd3) begin
               field_v             = 1'b1;
               field_r.tag         = (is_lost ? TAG_LOST_START : TAG_DLV_START)
                                     + {3'd0, eop_ff};
               field_r.value       = acc_shift;
               field_r.range_index = rc_ff;
               cnt_in              = '0;
               acc_in              = '0;
               if (eop_ff) begin
                  eop_in  = 1'b0;
                  rc_in   = rc_ff + 8'd1;
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     sec_in = next_section(sec_ff, flags_ff);
                  end
               end else begin
                  eop_in = 1'b1;
               end
            end else begin
               cnt_in = cnt_inc;
               acc_in = acc_shift;
            end
         end
         default: begin
         end
      endcase

      // count bytes, hold once the minimum length is reached
      if (pos_ff != PosWidth'(MinFrameBytes)) begin
         pos_in = pos_ff + PosWidth'(1);
      end

      if (pos_in < PosWidth'(MinFrameBytes)) begin
         st = ST_TOO_SHORT;
      end else if (err_in != ST_OK) begin
         st = err_in;
      end else if (sec_in != SEC_DONE) begin
         st = ST_TRUNCATED;
      end else begin
         st = ST_OK;
      end
      end_r.tag       = TAG_END_STATUS;
      end_r.status    = st;
      end_r.frame_end = 1'b1;

      if (accept) begin
         if (last_byte) begin
            if (field_v) begin
               push.count  = 2'd2;
               push.first  = field_r;
               push.second = end_r;
            end else begin
               push.count = 2'd1;
               push.first = end_r;
            end
         end else if (field_v) begin
            push.count = 2'd1;
            push.first = field_r;
         end
      end

      // clear frame state after the last byte
      if (last_byte) begin
         pos_in   = '0;
         flags_in = '0;
         sec_in   = SEC_HDR0;
         cnt_in   = '0;
         acc_in   = '0;
         left_in  = '0;
         rc_in    = '0;
         eop_in   = 1'b0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         flags_ff <= '0;
         sec_ff   <= SEC_HDR0;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         rc_ff    <= '0;
         eop_ff   <= 1'b0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
         sec_ff   <= sec_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         rc_ff    <= rc_in;
         eop_ff   <= eop_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: rtl/dsfp_queue.sv
`timescale 1ns / 1ps

module dsfp_queue
   import dsfp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_item
);

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   // two free slots cover the worst case of two results per byte
   assign room      = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/delivery_status_frame_parser_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_chan  in   valid/ready    data_byte[7:0], last_byte
// rsp_chan  out  valid/ready    tag[3:0], value[31:0], range_index[7:0], status[2:0], frame_end
// csr_*     in   csr_we         csr_index[1:0], csr_wdata[7:0]
//
// One byte per cycle while input ready is high: each byte is parsed in the cycle
// it is accepted and its results (one field, plus the end status on the last
// byte) land in a four-entry result queue. The queue drains one result per cycle
// while rsp_chan.ready is high, so the two results of one byte leave one after the
// other. Input ready drops while fewer than two queue slots are free. Reset is
// synchronous, clears the frame state and the queue and sets the registers to defaults.

module delivery_status_frame_parser_top
   import dsfp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   dsfp_req_if.sink                 req_chan,
   dsfp_rsp_if.source               rsp_chan,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type  cfg_ff;
   push_type push;
   logic     room;
   logic     accept;
   rsp_type  out_item;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_frame_type  <= 4'd1;
         cfg_ff.max_lost_ranges      <= 8'd255;
         cfg_ff.max_delivered_ranges <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_TYPE:    cfg_ff.expected_frame_type  <= csr_wdata[3:0];
            CSR_MAX_LOST:      cfg_ff.max_lost_ranges      <= csr_wdata;
            CSR_MAX_DELIVERED: cfg_ff.max_delivered_ranges <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dsfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .cfg       (cfg_ff),
      .push      (push)
   );

   dsfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.tag         = out_item.tag;
   assign rsp_chan.value       = out_item.value;
   assign rsp_chan.range_index = out_item.range_index;
   assign rsp_chan.status      = out_item.status;
   assign rsp_chan.frame_end   = out_item.frame_end;

endmodule
